FILE: src/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

  // Bits per byte on the bus
  localparam int unsigned DATA_BITS = 8;

  // Register file: half period at word 0, ACK timeout at word 1
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned TMO_W     = 8;
  localparam int unsigned BCNT_W    = 4;
  localparam logic [HALF_W-1:0] HALF_RESET = 16'd500;
  localparam logic [TMO_W-1:0]  TMO_RESET  = 8'd250;
  localparam logic REG_HALF = 1'b0;
  localparam logic REG_TMO  = 1'b1;

  // Command codes as carried on the input tuser
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // Command class decided by the front end
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_WR_TAIL,
    PH_AK_REL,
    PH_AK_HIGH,
    PH_AK_POLL,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_RA_LOW,
    PH_RA_HIGH
  } phase_t;

  // One classified tick waiting in the queue
  typedef struct packed {
    cmd_t                 cmd;
    logic [DATA_BITS-1:0] wr_data;
    logic                 send_ack;
    logic                 sda_in;
  } q_entry_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [HALF_W-1:0] half_period_ticks;
    logic [TMO_W-1:0]  ack_timeout;
  } cfg_regs_t;

  // One result word
  typedef struct packed {
    logic                 ack_ok;
    logic [DATA_BITS-1:0] rd_data;
    logic                 done_res;
    logic                 busy_res;
    logic                 sda_out;
    logic                 scl_out;
  } out_word_t;

endpackage

FILE: src/i2cm_front.sv
// Front end: classifies each input word and holds it in a short queue.
module i2cm_front
  import i2cm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [2:0]     in_tuser,   // [0] cmd_valid, [2:1] func
  input  logic [15:0]    in_tdata,   // [7:0] wr_data, [8] send_ack, [9] sda_in
  output logic           q_valid,
  input  logic           q_pop,
  output q_entry_t       q_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  q_entry_t             entry_in;
  logic                 push;

  // Classify the incoming word
  always_comb begin
    entry_in.wr_data  = in_tdata[DATA_BITS-1:0];
    entry_in.send_ack = in_tdata[DATA_BITS];
    entry_in.sda_in   = in_tdata[DATA_BITS+1];
    if (!in_tuser[0]) begin
      entry_in.cmd = CMD_NONE;
    end else begin
      case (in_tuser[2:1])
        FUNC_START: entry_in.cmd = CMD_START;
        FUNC_STOP:  entry_in.cmd = CMD_STOP;
        FUNC_WRITE: entry_in.cmd = CMD_WRITE;
        FUNC_READ:  entry_in.cmd = CMD_READ;
        default:    entry_in.cmd = CMD_NONE;
      endcase
    end
  end

  assign in_tready = (cnt_r != CNT_W'(DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_entry   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry_in;
    end
  end

endmodule

FILE: src/i2cm_back.sv
// Back end: the SCL/SDA bit sequencer and the registered result word.
module i2cm_back
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  output logic      out_tvalid,
  input  logic      out_tready,
  output out_word_t out_word
);

  phase_t               phase_r, phase_nxt;
  logic [BCNT_W-1:0]    bit_count_r, bit_count_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [HALF_W-1:0]    delay_r, delay_nxt;
  logic [TMO_W-1:0]     timeout_r, timeout_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 ack_choice_r, ack_choice_nxt;
  logic                 ack_result_r, ack_result_nxt;
  logic                 done_nxt;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  logic                 step;
  logic                 wait_done;
  logic                 last_bit;
  logic                 poll_fail;
  logic                 arm;
  logic [BCNT_W-1:0]    bit_inc;

  // Advance one tick when a word is queued and the result slot is free
  assign step      = q_valid && (!out_valid_r || out_tready);
  assign q_pop     = step;
  assign wait_done = (delay_r <= HALF_W'(1));
  assign bit_inc   = bit_count_r + BCNT_W'(1);
  assign last_bit  = (bit_inc >= BCNT_W'(DATA_BITS));
  assign poll_fail = (timeout_r >= cfg.ack_timeout);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        case (q_entry.cmd)
          CMD_START: phase_nxt = PH_ST_A;
          CMD_STOP:  phase_nxt = PH_SP_A;
          CMD_WRITE: phase_nxt = PH_WR_LOW;
          CMD_READ:  phase_nxt = PH_RD_LOW;
          default:   phase_nxt = PH_IDLE;
        endcase
      end
      PH_ST_A:    if (wait_done) phase_nxt = PH_ST_B;
      PH_ST_B:    if (wait_done) phase_nxt = PH_IDLE;
      PH_SP_A:    if (wait_done) phase_nxt = PH_SP_B;
      PH_SP_B:    if (wait_done) phase_nxt = PH_IDLE;
      PH_WR_LOW:  if (wait_done) phase_nxt = PH_WR_HIGH;
      PH_WR_HIGH: if (wait_done) phase_nxt = PH_WR_TAIL;
      PH_WR_TAIL: if (wait_done) phase_nxt = last_bit ? PH_AK_REL : PH_WR_LOW;
      PH_AK_REL:  if (wait_done) phase_nxt = PH_AK_HIGH;
      PH_AK_HIGH: if (wait_done) phase_nxt = PH_AK_POLL;
      PH_AK_POLL: begin
        if (!q_entry.sda_in) begin
          phase_nxt = PH_IDLE;
        end else if (poll_fail) begin
          phase_nxt = PH_SP_A;
        end
      end
      PH_RD_LOW:  if (wait_done) phase_nxt = PH_RD_HIGH;
      PH_RD_HIGH: if (wait_done) phase_nxt = last_bit ? PH_RA_LOW : PH_RD_LOW;
      PH_RA_LOW:  if (wait_done) phase_nxt = PH_RA_HIGH;
      PH_RA_HIGH: if (wait_done) phase_nxt = PH_IDLE;
      default:    phase_nxt = PH_IDLE;
    endcase
  end

  // A move into any timed phase reloads the half-period counter
  assign arm = (phase_nxt != phase_r) && (phase_nxt != PH_IDLE) &&
               (phase_nxt != PH_AK_POLL);

  // Line levels, shifter, counters and status
  always_comb begin
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    timeout_nxt    = timeout_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_choice_nxt = ack_choice_r;
    ack_result_nxt = ack_result_r;
    done_nxt       = 1'b0;
    delay_nxt      = delay_r;
    if (phase_r != PH_IDLE && phase_r != PH_AK_POLL) begin
      delay_nxt = wait_done ? '0 : delay_r - HALF_W'(1);
    end
    case (phase_r)
      PH_IDLE: begin
        case (q_entry.cmd)
          CMD_START: begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end
          CMD_STOP: begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b0;
          end
          CMD_WRITE: begin
            scl_nxt       = 1'b0;
            bit_count_nxt = '0;
            sda_nxt       = q_entry.wr_data[DATA_BITS-1];
            shift_nxt     = {q_entry.wr_data[DATA_BITS-2:0], 1'b0};
          end
          CMD_READ: begin
            sda_nxt        = 1'b1;
            scl_nxt        = 1'b0;
            bit_count_nxt  = '0;
            shift_nxt      = '0;
            ack_choice_nxt = q_entry.send_ack;
          end
          default: ;
        endcase
      end
      PH_ST_A: if (wait_done) sda_nxt = 1'b0;
      PH_ST_B: begin
        if (wait_done) begin
          scl_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      end
      PH_SP_A: if (wait_done) scl_nxt = 1'b1;
      PH_SP_B: begin
        if (wait_done) begin
          sda_nxt  = 1'b1;
          done_nxt = 1'b1;
        end
      end
      PH_WR_LOW:  if (wait_done) scl_nxt = 1'b1;
      PH_WR_HIGH: if (wait_done) scl_nxt = 1'b0;
      PH_WR_TAIL: begin
        if (wait_done) begin
          bit_count_nxt = bit_inc;
          if (last_bit) begin
            sda_nxt = 1'b1;
          end else begin
            sda_nxt   = shift_r[DATA_BITS-1];
            shift_nxt = {shift_r[DATA_BITS-2:0], 1'b0};
          end
        end
      end
      PH_AK_REL:  if (wait_done) scl_nxt = 1'b1;
      PH_AK_HIGH: if (wait_done) timeout_nxt = '0;
      PH_AK_POLL: begin
        if (!q_entry.sda_in) begin
          scl_nxt        = 1'b0;
          ack_result_nxt = 1'b1;
          done_nxt       = 1'b1;
        end else if (poll_fail) begin
          ack_result_nxt = 1'b0;
          scl_nxt        = 1'b0;
          sda_nxt        = 1'b0;
        end else begin
          timeout_nxt = timeout_r + TMO_W'(1);
        end
      end
      PH_RD_LOW: begin
        if (wait_done) begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[DATA_BITS-2:0], q_entry.sda_in};
        end
      end
      PH_RD_HIGH: begin
        if (wait_done) begin
          bit_count_nxt = bit_inc;
          scl_nxt       = 1'b0;
          if (last_bit) begin
            sda_nxt = !ack_choice_r;
          end
        end
      end
      PH_RA_LOW: if (wait_done) scl_nxt = 1'b1;
      PH_RA_HIGH: begin
        if (wait_done) begin
          scl_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    if (arm) begin
      delay_nxt = cfg.half_period_ticks;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_count_r  <= '0;
      shift_r      <= '0;
      delay_r      <= '0;
      timeout_r    <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_choice_r <= 1'b0;
      ack_result_r <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      delay_r      <= delay_nxt;
      timeout_r    <= timeout_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_choice_r <= ack_choice_nxt;
      ack_result_r <= ack_result_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word_r.scl_out  <= scl_nxt;
      out_word_r.sda_out  <= sda_nxt;
      out_word_r.busy_res <= (phase_nxt != PH_IDLE);
      out_word_r.done_res <= done_nxt;
      out_word_r.rd_data  <= shift_nxt;
      out_word_r.ack_ok   <= ack_result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_word   = out_word_r;

`ifndef SYNTHESIS
  // A completion word never reports the engine busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.done_res |-> !out_word_r.busy_res)
    else $error("done reported while busy");

  // Bit counter never passes the byte length
  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= BCNT_W'(DATA_BITS))
    else $error("bit counter overran");

  // The half-period counter is spent whenever the engine is idle
  a_idle_delay_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> delay_r == '0)
    else $error("delay counter live in idle");

  // Every step leaves a result word pending
  a_step_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("step without result word");
`endif

endmodule

FILE: src/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: register port, front queue and bit sequencer.
//
// Each input word is one system tick carrying an optional command (START, STOP,
// WRITE BYTE, READ BYTE) and the sampled SDA level; each accepted word yields
// exactly one result word with the SCL/SDA drive levels, busy/done flags, the
// shift register and the last ACK result. While results are taken the block
// sustains one word per clock: words enter a QUEUE_DEPTH-entry queue and the
// sequencer retires one per cycle whenever the result register is empty or being
// drained; a word passes the queue, then the result register. Bus timing is
// counted in words, not clocks: each timed phase lasts max(1, half_period_ticks)
// words. Registers: 0x0 half_period_ticks (16 bit, reset 500), 0x4 ack_timeout
// (8 bit, reset 250); write them only while the engine is idle.
module i2c_master_byte_engine_core
  import i2cm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [0] cmd_valid, [2:1] func
  input  logic [15:0] in_tdata,   // [7:0] wr_data, [8] send_ack, [9] sda_in, rest zero
  // Result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] scl_out, [1] sda_out, [2] busy_res,
                                  // [3] done_res, [11:4] rd_data, [12] ack_ok
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [HALF_W-1:0] half_r;
  logic [TMO_W-1:0]  tmo_r;
  logic              wr_en;
  cfg_regs_t         cfg;
  logic              q_valid;
  logic              q_pop;
  q_entry_t          q_entry;
  out_word_t         out_word;

  // Register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RESET;
      tmo_r  <= TMO_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_HALF) begin
        half_r <= pwdata[HALF_W-1:0];
      end else begin
        tmo_r <= pwdata[TMO_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_TMO) begin
      prdata = {{(32-TMO_W){1'b0}}, tmo_r};
    end else begin
      prdata = {{(32-HALF_W){1'b0}}, half_r};
    end
  end

  assign cfg.half_period_ticks = half_r;
  assign cfg.ack_timeout       = tmo_r;

  i2cm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (out_word)
  );

  // Pack the result word
  assign out_tdata = {3'b000, out_word};

endmodule

FILE: tb/sv/tb_i2c_master_byte_engine_core.sv
// Self-checking testbench for the I2C master byte engine core: tick predictor, stimulus, checks.
module tb_i2c_master_byte_engine_core
  import i2cm_pkg::*;
();

  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_WORDS  = 270;
  localparam int NEVER_ACK    = 1000;
  localparam int SETTLE_TICKS = 20;
  localparam logic [2:0] ADDR_HALF = {REG_HALF, 2'b00};
  localparam logic [2:0] ADDR_TMO  = {REG_TMO, 2'b00};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser   = '0;   // [0] cmd_valid, [2:1] func
  logic [15:0] in_tdata   = '0;   // [7:0] wr_data, [8] send_ack, [9] sda_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [0] scl, [1] sda, [2] busy, [3] done, [11:4] rd, [12] ack
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_byte_engine_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bus engine mirror: configuration and sequencer state
  logic [HALF_W-1:0]    half_ticks = HALF_RESET;
  logic [TMO_W-1:0]     ack_limit  = TMO_RESET;
  phase_t               seq_phase  = PH_IDLE;
  logic [BCNT_W-1:0]    bit_cnt    = '0;
  logic [DATA_BITS-1:0] shifter    = '0;
  logic [HALF_W-1:0]    wait_cnt   = '0;
  logic [TMO_W-1:0]     poll_cnt   = '0;
  logic                 scl_lvl    = 1'b1;
  logic                 sda_lvl    = 1'b1;
  logic                 ack_pick   = 1'b0;
  logic                 ack_seen   = 1'b0;

  // Expected result words, oldest first
  out_word_t tick_q[$];

  int mismatches    = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int cmd_count[4]  = '{default: 0};
  int acked         = 0;
  int refused       = 0;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int quiet_cycles  = 0;

  function automatic void load_wait(input phase_t nxt);
    seq_phase = nxt;
    wait_cnt  = half_ticks;
  endfunction

  // Zero and one both mean a single tick of wait
  function automatic bit wait_done();
    if (wait_cnt > 1) begin
      wait_cnt--;
      return 1'b0;
    end
    wait_cnt = '0;
    return 1'b1;
  endfunction

  function automatic void drive_next_bit();
    sda_lvl = shifter[DATA_BITS-1];
    shifter = shifter << 1;
    load_wait(PH_WR_LOW);
  endfunction

  // One tick of the engine; returns the result word it produces
  function automatic out_word_t bus_tick(input logic cv, input logic [1:0] fn,
                                         input logic [7:0] wr, input logic sa,
                                         input logic sda);
    out_word_t w;
    logic      done;
    done = 1'b0;
    case (seq_phase)
      PH_IDLE: if (cv) begin
        case (fn)
          FUNC_START: begin
            sda_lvl = 1'b1; scl_lvl = 1'b1; load_wait(PH_ST_A);
          end
          FUNC_STOP: begin
            scl_lvl = 1'b0; sda_lvl = 1'b0; load_wait(PH_SP_A);
          end
          FUNC_WRITE: begin
            scl_lvl = 1'b0; bit_cnt = '0; shifter = wr; drive_next_bit();
          end
          FUNC_READ: begin
            sda_lvl = 1'b1; scl_lvl = 1'b0; bit_cnt = '0; shifter = '0;
            ack_pick = sa; load_wait(PH_RD_LOW);
          end
          default: ;
        endcase
      end
      PH_ST_A: if (wait_done()) begin
        sda_lvl = 1'b0; load_wait(PH_ST_B);
      end
      PH_ST_B: if (wait_done()) begin
        scl_lvl = 1'b0; seq_phase = PH_IDLE; done = 1'b1;
      end
      PH_SP_A: if (wait_done()) begin
        scl_lvl = 1'b1; load_wait(PH_SP_B);
      end
      PH_SP_B: if (wait_done()) begin
        sda_lvl = 1'b1; seq_phase = PH_IDLE; done = 1'b1;
      end
      PH_WR_LOW: if (wait_done()) begin
        scl_lvl = 1'b1; load_wait(PH_WR_HIGH);
      end
      PH_WR_HIGH: if (wait_done()) begin
        scl_lvl = 1'b0; load_wait(PH_WR_TAIL);
      end
      PH_WR_TAIL: if (wait_done()) begin
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt < DATA_BITS) begin
          drive_next_bit();
        end else begin
          sda_lvl = 1'b1; load_wait(PH_AK_REL);
        end
      end
      PH_AK_REL: if (wait_done()) begin
        scl_lvl = 1'b1; load_wait(PH_AK_HIGH);
      end
      PH_AK_HIGH: if (wait_done()) begin
        poll_cnt = '0; seq_phase = PH_AK_POLL;
      end
      // Slave pulls SDA low to acknowledge; too many high samples end in a stop
      PH_AK_POLL: begin
        if (!sda) begin
          scl_lvl = 1'b0; ack_seen = 1'b1; seq_phase = PH_IDLE; done = 1'b1;
        end else if (poll_cnt >= ack_limit) begin
          ack_seen = 1'b0; scl_lvl = 1'b0; sda_lvl = 1'b0; load_wait(PH_SP_A);
        end else begin
          poll_cnt = poll_cnt + 1'b1;
        end
      end
      PH_RD_LOW: if (wait_done()) begin
        scl_lvl = 1'b1;
        shifter = {shifter[DATA_BITS-2:0], sda};
        load_wait(PH_RD_HIGH);
      end
      PH_RD_HIGH: if (wait_done()) begin
        bit_cnt = bit_cnt + 1'b1;
        scl_lvl = 1'b0;
        if (bit_cnt < DATA_BITS) begin
          load_wait(PH_RD_LOW);
        end else begin
          sda_lvl = ~ack_pick; load_wait(PH_RA_LOW);
        end
      end
      PH_RA_LOW: if (wait_done()) begin
        scl_lvl = 1'b1; load_wait(PH_RA_HIGH);
      end
      PH_RA_HIGH: if (wait_done()) begin
        scl_lvl = 1'b0; seq_phase = PH_IDLE; done = 1'b1;
      end
      default: seq_phase = PH_IDLE;
    endcase
    w.scl_out  = scl_lvl;
    w.sda_out  = sda_lvl;
    w.busy_res = (seq_phase != PH_IDLE);
    w.done_res = done;
    w.rd_data  = shifter;
    w.ack_ok   = ack_seen;
    return w;
  endfunction

  function automatic void match(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[12:0];
      if (tick_q.size() == 0) begin
        $error("result word %h arrived with nothing expected", out_tdata);
        mismatches++;
      end else begin
        want = tick_q.pop_front();
        match("scl_out",  want.scl_out,  got.scl_out);
        match("sda_out",  want.sda_out,  got.sda_out);
        match("busy_res", want.busy_res, got.busy_res);
        match("done_res", want.done_res, got.done_res);
        match("rd_data",  want.rd_data,  got.rd_data);
        match("ack_ok",   want.ack_ok,   got.ack_ok);
        words_checked++;
      end
    end
  end

  // Watchdog: cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d words outstanding",
               quiet_cycles, tick_q.size());
      $display("tb_i2c_master_byte_engine_core: errors");
      $finish;
    end
  end

  // Offer one tick word, wait for it to be taken, then predict its result
  task automatic send_word(input logic cv, input logic [1:0] fn, input logic [7:0] wr,
                           input logic sa, input logic sda);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {fn, cv};
    in_tdata  <= {6'b0, sda, sa, wr};
    do @(posedge clk); while (!in_tready);
    tick_q.push_back(bus_tick(cv, fn, wr, sa, sda));
    words_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait for every expected word to come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tick_q.size() != 0) @(negedge clk);
  endtask

  // Issue a command and feed ticks until the engine is idle again.
  // SDA follows rd_pattern on read sampling ticks and goes low after
  // ack_after polls of the ACK clock; elsewhere it is random.
  task automatic run_cmd(input logic [1:0] fn, input logic [7:0] wr, input logic sa,
                         input logic [7:0] rd_pattern, input int ack_after,
                         input int noise_pct);
    logic sda;
    send_word(1'b1, fn, wr, sa, 1'($urandom_range(1)));
    cmd_count[fn]++;
    while (seq_phase != PH_IDLE) begin
      case (seq_phase)
        PH_RD_LOW:  sda = rd_pattern[DATA_BITS-1-bit_cnt];
        PH_AK_POLL: sda = (poll_cnt < ack_after);
        default:    sda = $urandom_range(1);
      endcase
      // commands offered while busy must be ignored
      send_word($urandom_range(99) < noise_pct, 2'($urandom_range(3)),
                8'($urandom_range(255)), 1'($urandom_range(1)), sda);
    end
    if (fn == FUNC_WRITE) begin
      if (ack_seen) acked++;
      else refused++;
    end
  endtask

  // One register access: setup cycle, then access cycle
  task automatic reg_access(input logic wr_en, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr_en;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr_en) begin
      if (addr == ADDR_HALF) half_ticks = wdata[HALF_W-1:0];
      else if (addr == ADDR_TMO) ack_limit = wdata[TMO_W-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_regs();
    logic [31:0] rdata;
    reg_access(1'b0, ADDR_HALF, '0, rdata);
    match("half_period_ticks", half_ticks, rdata);
    reg_access(1'b0, ADDR_TMO, '0, rdata);
    match("ack_timeout", ack_limit, rdata);
  endtask

  // Reprogram both registers once the engine has gone quiet
  task automatic set_config(input logic [HALF_W-1:0] half, input logic [TMO_W-1:0] tmo);
    logic [31:0] rdata;
    settle();
    reg_access(1'b1, ADDR_HALF, 32'(half), rdata);
    reg_access(1'b1, ADDR_TMO, 32'(tmo), rdata);
    check_regs();
  endtask

  task automatic random_cmd(input logic [1:0] fn);
    run_cmd(fn, 8'($urandom_range(255)), 1'($urandom_range(1)), 8'($urandom_range(255)),
            ($urandom_range(3) == 0) ? NEVER_ACK : int'($urandom_range(ack_limit + 1)), 20);
    repeat ($urandom_range(2))
      send_word(1'b0, 2'($urandom_range(3)), 8'($urandom_range(255)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Mostly framed transfers, now and then a lone command
  task automatic random_transfer();
    if ($urandom_range(4) == 0) begin
      random_cmd(2'($urandom_range(3)));
    end else begin
      random_cmd(FUNC_START);
      repeat ($urandom_range(1, 3))
        random_cmd($urandom_range(1) ? FUNC_WRITE : FUNC_READ);
      random_cmd(FUNC_STOP);
    end
  endtask

  task automatic test_reg_reset();
    check_regs();
  endtask

  // Every command, both ACK outcomes, edge data patterns, busy commands
  task automatic test_each_command();
    set_config(16'd1, 8'd3);
    run_cmd(FUNC_START, 8'h00, 1'b0, 8'h00, 0, 0);
    run_cmd(FUNC_WRITE, 8'hFF, 1'b0, 8'h00, 0, 0);
    run_cmd(FUNC_WRITE, 8'h00, 1'b0, 8'h00, 2, 0);
    run_cmd(FUNC_WRITE, 8'hA5, 1'b0, 8'h00, 3, 0);
    run_cmd(FUNC_WRITE, 8'h5A, 1'b0, 8'h00, NEVER_ACK, 0);
    run_cmd(FUNC_READ,  8'h00, 1'b1, 8'hFF, 0, 0);
    run_cmd(FUNC_READ,  8'hFF, 1'b0, 8'h00, 0, 0);
    run_cmd(FUNC_READ,  8'h00, 1'b1, 8'h96, 0, 100);
    run_cmd(FUNC_WRITE, 8'h3C, 1'b1, 8'h00, 1, 100);
    run_cmd(FUNC_STOP,  8'h00, 1'b0, 8'h00, 0, 100);
  endtask

  // Zero half period and timeout, then the largest of each; the largest
  // half period is only taken through its register
  task automatic test_limits();
    set_config(16'd0, 8'd0);
    run_cmd(FUNC_START, 8'h00, 1'b0, 8'h00, 0, 0);
    run_cmd(FUNC_WRITE, 8'hFF, 1'b0, 8'h00, NEVER_ACK, 0);
    run_cmd(FUNC_WRITE, 8'h81, 1'b0, 8'h00, 0, 0);
    run_cmd(FUNC_READ,  8'h00, 1'b0, 8'h69, 0, 0);
    run_cmd(FUNC_STOP,  8'h00, 1'b0, 8'h00, 0, 0);
    set_config(16'hFFFF, 8'hFF);
    set_config(16'd1, 8'hFF);
    run_cmd(FUNC_WRITE, 8'hC3, 1'b0, 8'h00, 255, 0);
    run_cmd(FUNC_WRITE, 8'h7E, 1'b0, 8'h00, NEVER_ACK, 0);
  endtask

  // Random traffic under four flow-control regimes
  task automatic test_random_traffic();
    int gap_pct[4]   = '{0, 81, 0, 19};
    int stall_pct[4] = '{0, 0, 81, 19};
    int first;
    for (int p = 0; p < 4; p++) begin
      set_config(16'($urandom_range(2)), 8'($urandom_range(6)));
      in_gap_pct    = gap_pct[p];
      out_stall_pct = stall_pct[p];
      first = words_sent;
      while (words_sent - first < PHASE_WORDS) random_transfer();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reg_reset();
    test_each_command();
    test_limits();
    test_random_traffic();

    settle();
    repeat (SETTLE_TICKS) @(posedge clk);
    $display("run covered %0d tick words, %0d results checked", words_sent, words_checked);
    $display("commands: %0d start, %0d stop, %0d write (%0d acked, %0d timed out), %0d read",
             cmd_count[FUNC_START], cmd_count[FUNC_STOP], cmd_count[FUNC_WRITE],
             acked, refused, cmd_count[FUNC_READ]);
    if (mismatches == 0)
      $display("tb_i2c_master_byte_engine_core: clean");
    else
      $display("tb_i2c_master_byte_engine_core: errors");
    $finish;
  end

endmodule
